@@ design/hfd_pkg.sv @@
// Shared types and constants for the Huffman table decoder.
`timescale 1ns / 1ps
package hfd_pkg;

	localparam int MAX_CODE_LEN  = 32;
	localparam int TABLE_ENTRIES = 256;
	localparam int BITS_PER_BYTE = 8;
	localparam int QUEUE_DEPTH   = 2;

	localparam int CODE_W  = 32;
	localparam int LEN_W   = 6;
	localparam int SYM_W   = 8;
	localparam int BYTE_W  = 8;
	localparam int IDX_W   = $clog2(TABLE_ENTRIES);
	localparam int ADDR_W  = $clog2(TABLE_ENTRIES + 1);
	localparam int PLEN_W  = $clog2(MAX_CODE_LEN + 1);
	localparam int CMP_W   = (PLEN_W > LEN_W) ? PLEN_W : LEN_W;
	localparam int PAD_W   = $clog2(BITS_PER_BYTE + 1);
	localparam int ENTRY_W = LEN_W + CODE_W;
	localparam int QPTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_OVERFLOW = 2'd1;
	localparam logic [1:0] STATUS_PADDING  = 2'd2;

	localparam logic MODE_LOAD = 1'b0;

	typedef enum logic [1:0] {
		CMD_LOAD,
		CMD_HEADER,
		CMD_DATA
	} hfd_kind_t;

	typedef struct packed {
		logic              mode;
		logic [SYM_W-1:0]  entry_symbol;
		logic [CODE_W-1:0] entry_code;
		logic [LEN_W-1:0]  entry_length;
		logic [BYTE_W-1:0] data_byte;
		logic              last_byte;
	} hfd_item_t;

	typedef struct packed {
		logic [SYM_W-1:0] symbol;
		logic             symbol_valid;
		logic             end_of_stream;
		logic [1:0]       status;
	} hfd_result_t;

	typedef struct packed {
		hfd_kind_t         kind;
		logic              pad_err;
		logic              last;
		logic [PAD_W-1:0]  nbits;
		logic [BYTE_W-1:0] data;
		logic [SYM_W-1:0]  sym;
		logic [CODE_W-1:0] code;
		logic [LEN_W-1:0]  len;
	} hfd_cmd_t;

endpackage

@@ design/hfd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module hfd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ design/hfd_front.sv @@
// Front end: accepts input words, tracks stream header, classifies into commands.
`timescale 1ns / 1ps
module hfd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  hfd_pkg::hfd_item_t item,
	input  logic              item_valid,
	output logic              item_ready,
	input  logic              queue_full,
	output hfd_pkg::hfd_cmd_t  cmd,
	output logic              cmd_push
);
	import hfd_pkg::*;

	logic             hdr_q;
	logic [PAD_W-1:0] pad_q;
	logic             pad_err;

	assign item_ready = !queue_full;
	assign cmd_push   = item_valid && item_ready;
	assign pad_err    = item.data_byte > BYTE_W'(BITS_PER_BYTE);

	always_comb begin
		cmd.pad_err = pad_err;
		cmd.last    = item.last_byte;
		cmd.data    = item.data_byte;
		cmd.sym     = item.entry_symbol;
		cmd.code    = item.entry_code;
		cmd.len     = item.entry_length;
		cmd.nbits   = item.last_byte ? PAD_W'(BITS_PER_BYTE) - pad_q : PAD_W'(BITS_PER_BYTE);
		if (item.mode == MODE_LOAD) begin
			cmd.kind = CMD_LOAD;
		end else if (hdr_q) begin
			cmd.kind = CMD_HEADER;
		end else begin
			cmd.kind = CMD_DATA;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_q <= 1'b1;
			pad_q <= '0;
		end else if (cmd_push && item.mode != MODE_LOAD) begin
			hdr_q <= item.last_byte;
			if (hdr_q) begin
				pad_q <= pad_err ? PAD_W'(BITS_PER_BYTE) : item.data_byte[PAD_W-1:0];
			end
		end
	end

endmodule

@@ design/hfd_queue.sv @@
// Short command queue between front end and decode engine.
`timescale 1ns / 1ps
module hfd_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  hfd_pkg::hfd_cmd_t  wr_cmd,
	input  logic              push,
	output logic              full,
	output hfd_pkg::hfd_cmd_t  rd_cmd,
	output logic              not_empty,
	input  logic              pop
);
	import hfd_pkg::*;

	hfd_cmd_t          slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wptr_q;
	logic [QPTR_W-1:0] rptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full      = cnt_q == QCNT_W'(QUEUE_DEPTH);
	assign not_empty = cnt_q != '0;
	assign rd_cmd    = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

@@ design/hfd_back.sv @@
// Decode engine: table writes, bitwise code build, sequential table scan, result output.
`timescale 1ns / 1ps
module hfd_back (
	input  logic                clk,
	input  logic                arst_n,
	input  hfd_pkg::hfd_cmd_t    cmd,
	input  logic                cmd_valid,
	output logic                cmd_pop,
	output hfd_pkg::hfd_result_t result,
	output logic                result_valid,
	input  logic                result_ready
);
	import hfd_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SHIFT,
		S_SCAN,
		S_PUSH,
		S_FLUSH
	} state_t;

	state_t             state_q;
	logic               last_q;
	logic [PAD_W-1:0]   nbits_q;
	logic [PAD_W-1:0]   bcnt_q;
	logic [BYTE_W-1:0]  byte_q;
	logic [CODE_W-1:0]  code_q;
	logic [CODE_W-1:0]  mask_q;
	logic [PLEN_W-1:0]  plen_q;
	logic [ADDR_W-1:0]  addr_q;
	logic               cmp_v_q;
	logic               cmp_vbit_q;
	logic [IDX_W-1:0]   cmp_idx_q;
	logic [TABLE_ENTRIES-1:0] valid_q;
	hfd_result_t        res_q;
	hfd_result_t        held_q;
	logic               held_v_q;
	hfd_result_t        out_q;
	logic               out_v_q;

	logic               in_range;
	logic               ram_we;
	logic [ENTRY_W-1:0] ram_wdata;
	logic [ENTRY_W-1:0] ram_rdata;
	logic [LEN_W-1:0]   len_e;
	logic [CODE_W-1:0]  code_e;
	logic               hit;
	logic               scan_done;
	logic               out_free;
	logic               out_load;

	assign in_range  = {1'b0, cmd.sym} < (SYM_W+1)'(TABLE_ENTRIES);
	assign cmd_pop   = (state_q == S_IDLE) && cmd_valid;
	assign ram_we    = cmd_pop && (cmd.kind == CMD_LOAD) && in_range;
	assign ram_wdata = {cmd.len, cmd.code};
	assign len_e     = ram_rdata[ENTRY_W-1:CODE_W];
	assign code_e    = ram_rdata[CODE_W-1:0];
	assign hit       = cmp_v_q && cmp_vbit_q
		&& (CMP_W'(len_e) == CMP_W'(plen_q))
		&& (len_e <= LEN_W'(CODE_W))
		&& (((code_e ^ code_q) & mask_q) == '0);
	assign scan_done = !cmp_v_q && (addr_q == ADDR_W'(TABLE_ENTRIES));
	assign out_free  = !out_v_q || result_ready;
	assign out_load  = out_free && (((state_q == S_PUSH) && held_v_q)
		|| ((state_q == S_FLUSH) && (held_v_q || last_q)));

	assign result       = out_q;
	assign result_valid = out_v_q;

	hfd_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_ENTRIES)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(cmd.sym[IDX_W-1:0]),
		.wdata(ram_wdata),
		.raddr(addr_q[IDX_W-1:0]),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			last_q     <= 1'b0;
			nbits_q    <= '0;
			bcnt_q     <= '0;
			byte_q     <= '0;
			code_q     <= '0;
			mask_q     <= '0;
			plen_q     <= '0;
			addr_q     <= '0;
			cmp_v_q    <= 1'b0;
			cmp_vbit_q <= 1'b0;
			cmp_idx_q  <= '0;
			valid_q    <= '0;
			res_q      <= '0;
			held_q     <= '0;
			held_v_q   <= 1'b0;
			out_q      <= '0;
			out_v_q    <= 1'b0;
		end else begin
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (result_ready) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						last_q <= cmd.last;
						case (cmd.kind)
							CMD_LOAD: begin
								if (in_range) begin
									valid_q[cmd.sym[IDX_W-1:0]] <= 1'b1;
								end
							end
							CMD_HEADER: begin
								if (cmd.pad_err) begin
									held_q   <= '{symbol: '0, symbol_valid: 1'b0,
										end_of_stream: 1'b0, status: STATUS_PADDING};
									held_v_q <= 1'b1;
								end
								state_q <= S_FLUSH;
							end
							CMD_DATA: begin
								nbits_q <= cmd.nbits;
								bcnt_q  <= '0;
								byte_q  <= cmd.data;
								state_q <= S_SHIFT;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_SHIFT: begin
					if (bcnt_q == nbits_q) begin
						state_q <= S_FLUSH;
					end else begin
						code_q  <= {code_q[CODE_W-2:0], byte_q[BYTE_W-1]};
						mask_q  <= {mask_q[CODE_W-2:0], 1'b1};
						plen_q  <= plen_q + 1'b1;
						byte_q  <= {byte_q[BYTE_W-2:0], 1'b0};
						bcnt_q  <= bcnt_q + 1'b1;
						addr_q  <= '0;
						cmp_v_q <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (addr_q != ADDR_W'(TABLE_ENTRIES)) begin
						cmp_v_q    <= 1'b1;
						cmp_idx_q  <= addr_q[IDX_W-1:0];
						cmp_vbit_q <= valid_q[addr_q[IDX_W-1:0]];
						addr_q     <= addr_q + 1'b1;
					end else begin
						cmp_v_q <= 1'b0;
					end
					if (hit) begin
						res_q   <= '{symbol: SYM_W'(cmp_idx_q), symbol_valid: 1'b1,
							end_of_stream: 1'b0, status: STATUS_OK};
						code_q  <= '0;
						mask_q  <= '0;
						plen_q  <= '0;
						state_q <= S_PUSH;
					end else if (scan_done) begin
						if (plen_q >= PLEN_W'(MAX_CODE_LEN)) begin
							res_q   <= '{symbol: '0, symbol_valid: 1'b0,
								end_of_stream: 1'b0, status: STATUS_OVERFLOW};
							code_q  <= '0;
							mask_q  <= '0;
							plen_q  <= '0;
							state_q <= S_PUSH;
						end else begin
							state_q <= S_SHIFT;
						end
					end
				end
				S_PUSH: begin
					if (!held_v_q) begin
						held_q   <= res_q;
						held_v_q <= 1'b1;
						state_q  <= S_SHIFT;
					end else if (out_free) begin
						out_q   <= held_q;
						held_q  <= res_q;
						state_q <= S_SHIFT;
					end
				end
				S_FLUSH: begin
					if (held_v_q || last_q) begin
						if (out_free) begin
							if (held_v_q) begin
								out_q <= '{symbol: held_q.symbol,
									symbol_valid: held_q.symbol_valid,
									end_of_stream: last_q, status: held_q.status};
							end else begin
								out_q <= '{symbol: '0, symbol_valid: 1'b0,
									end_of_stream: 1'b1, status: STATUS_OK};
							end
							held_v_q <= 1'b0;
							if (last_q) begin
								code_q <= '0;
								mask_q <= '0;
								plen_q <= '0;
							end
							state_q <= S_IDLE;
						end
					end else begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

@@ design/huffman_table_decoder.sv @@
// Huffman table decoder top level: front end, command queue, decode engine.
// A stream byte is decoded bit by bit, with a table scan of one entry per cycle for each bit.
// The queue holds QUEUE_DEPTH words, so input is taken while the engine works on an earlier word.
// Reset clears all table valid bits, the code state, the queue and the output register.
`timescale 1ns / 1ps
module huffman_table_decoder (
	input  logic                clk,
	input  logic                arst_n,
	input  hfd_pkg::hfd_item_t   item,
	input  logic                item_valid,
	output logic                item_ready,
	output hfd_pkg::hfd_result_t result,
	output logic                result_valid,
	input  logic                result_ready
);
	import hfd_pkg::*;

	hfd_cmd_t push_cmd;
	hfd_cmd_t head_cmd;
	logic     push;
	logic     full;
	logic     not_empty;
	logic     pop;

	hfd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.queue_full(full),
		.cmd       (push_cmd),
		.cmd_push  (push)
	);

	hfd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_cmd   (push_cmd),
		.push     (push),
		.full     (full),
		.rd_cmd   (head_cmd),
		.not_empty(not_empty),
		.pop      (pop)
	);

	hfd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (head_cmd),
		.cmd_valid   (not_empty),
		.cmd_pop     (pop),
		.result      (result),
		.result_valid(result_valid),
		.result_ready(result_ready)
	);

endmodule

@@ design/hfd_checker.sv @@
// Port-level checks for the Huffman table decoder, bound to the top level.
`timescale 1ns / 1ps
module hfd_checker (
	input logic                clk,
	input logic                arst_n,
	input hfd_pkg::hfd_result_t result,
	input logic                result_valid,
	input logic                result_ready
);
	import hfd_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result word dropped or changed while stalled");

	a_sym_ok: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.symbol_valid |-> result.status == STATUS_OK)
		else $error("decoded symbol carries error status");

	a_nosym_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.symbol_valid |-> result.symbol == '0)
		else $error("nonzero symbol without symbol_valid");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.status == STATUS_OK || result.status == STATUS_OVERFLOW
			|| result.status == STATUS_PADDING)
		else $error("undefined status code");

	a_overflow_mid: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status == STATUS_OVERFLOW && !result.end_of_stream
			|-> !result.symbol_valid)
		else $error("overflow word marked as symbol");

endmodule

bind huffman_table_decoder hfd_checker u_hfd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.result      (result),
	.result_valid(result_valid),
	.result_ready(result_ready)
);

@@ verif/hfd_checker.sv @@
// Scoreboard for the Huffman table decoder: tracks table and stream state, checks each result word.
`timescale 1ns / 1ps
module hfd_scoreboard (
	input  logic                 clk,
	input  logic                 arst_n,
	input  hfd_pkg::hfd_item_t   item,
	input  logic                 item_valid,
	input  logic                 item_ready,
	input  hfd_pkg::hfd_result_t result,
	input  logic                 result_valid,
	input  logic                 result_ready,
	output int                   mismatches,
	output int                   outstanding
);
	import hfd_pkg::*;

	logic [LEN_W-1:0]  len_tab  [TABLE_ENTRIES];
	logic [CODE_W-1:0] code_tab [TABLE_ENTRIES];
	logic [CODE_W-1:0] acc_code;
	int                acc_len;
	bit                in_stream;
	int                pad_bits;
	hfd_result_t       decoded_q [$];
	hfd_result_t       want;

	function automatic hfd_result_t mk(input logic [SYM_W-1:0] sym, input logic vld,
			input logic eos, input logic [1:0] st);
		hfd_result_t r;
		r.symbol        = sym;
		r.symbol_valid  = vld;
		r.end_of_stream = eos;
		r.status        = st;
		return r;
	endfunction

	task automatic end_stream();
		acc_code  = '0;
		acc_len   = 0;
		in_stream = 1'b0;
		pad_bits  = 0;
	endtask

	task automatic decode_word(input hfd_item_t w);
		int          nbits;
		int          hit;
		int          made;
		logic [63:0] mask;
		hfd_result_t r;
		if (w.mode == MODE_LOAD) begin
			len_tab[w.entry_symbol]  = w.entry_length;
			code_tab[w.entry_symbol] = w.entry_code;
		end else if (!in_stream) begin
			// header word carries the padding count
			in_stream = 1'b1;
			pad_bits  = int'(w.data_byte);
			if (w.data_byte > BITS_PER_BYTE) begin
				pad_bits = BITS_PER_BYTE;
				decoded_q.push_back(mk('0, 1'b0, w.last_byte, STATUS_PADDING));
			end else if (w.last_byte) begin
				decoded_q.push_back(mk('0, 1'b0, 1'b1, STATUS_OK));
			end
			if (w.last_byte)
				end_stream();
		end else begin
			made  = 0;
			nbits = w.last_byte ? BITS_PER_BYTE - pad_bits : BITS_PER_BYTE;
			for (int b = 0; b < nbits; b++) begin
				acc_code = {acc_code[CODE_W-2:0], w.data_byte[BYTE_W-1-b]};
				acc_len++;
				hit = -1;
				for (int i = 0; i < TABLE_ENTRIES && hit < 0; i++) begin
					mask = (64'd1 << len_tab[i]) - 64'd1;
					if (len_tab[i] != 0 && len_tab[i] <= CODE_W &&
							len_tab[i] <= MAX_CODE_LEN && len_tab[i] == acc_len &&
							(({32'd0, code_tab[i] ^ acc_code}) & mask) == 0)
						hit = i;
				end
				if (hit >= 0) begin
					decoded_q.push_back(mk(SYM_W'(hit), 1'b1, 1'b0, STATUS_OK));
					made++;
					acc_code = '0;
					acc_len  = 0;
				end else if (acc_len >= MAX_CODE_LEN) begin
					decoded_q.push_back(mk('0, 1'b0, 1'b0, STATUS_OVERFLOW));
					made++;
					acc_code = '0;
					acc_len  = 0;
				end
			end
			if (w.last_byte) begin
				if (made == 0) begin
					decoded_q.push_back(mk('0, 1'b0, 1'b1, STATUS_OK));
				end else begin
					r = decoded_q.pop_back();
					r.end_of_stream = 1'b1;
					decoded_q.push_back(r);
				end
				end_stream();
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				len_tab[i]  = '0;
				code_tab[i] = '0;
			end
			end_stream();
			decoded_q.delete();
			mismatches  = 0;
			outstanding = 0;
		end else begin
			if (result_valid && result_ready) begin
				if (decoded_q.size() == 0) begin
					$display("%0t: result word with none expected: sym=%02h v=%0b eos=%0b st=%0d",
						$time, result.symbol, result.symbol_valid, result.end_of_stream,
						result.status);
					mismatches++;
				end else begin
					want = decoded_q.pop_front();
					if (result.symbol !== want.symbol ||
							result.symbol_valid !== want.symbol_valid ||
							result.end_of_stream !== want.end_of_stream ||
							result.status !== want.status) begin
						$display({"%0t: result mismatch: exp sym=%02h v=%0b eos=%0b st=%0d,",
							" got sym=%02h v=%0b eos=%0b st=%0d"},
							$time, want.symbol, want.symbol_valid, want.end_of_stream,
							want.status, result.symbol, result.symbol_valid,
							result.end_of_stream, result.status);
						mismatches++;
					end
				end
			end
			if (item_valid && item_ready)
				decode_word(item);
			outstanding = decoded_q.size();
		end
	end

endmodule

@@ verif/tb_top.sv @@
// Top of the Huffman table decoder bench: loads code tables, sends streams, reports the verdict.
`timescale 1ns / 1ps
module tb_top;
	import hfd_pkg::*;

	localparam logic MODE_BYTE    = 1'b1;
	localparam int   ITEM_COUNT   = 110;
	localparam int   QUIET_LIMIT  = 10000;
	localparam int   DRAIN_CYCLES = 2200;

	logic        clk;
	logic        arst_n;
	hfd_item_t   item;
	logic        item_valid;
	logic        item_ready;
	hfd_result_t result;
	logic        result_valid;
	logic        result_ready;

	int mismatches;
	int outstanding;
	int quiet = 0;
	int burst_left;
	int words_sent;
	bit rdy_on;
	int rdy_run;
	int loaded_syms [$];

	huffman_table_decoder uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.result       (result),
		.result_valid (result_valid),
		.result_ready (result_ready)
	);

	hfd_scoreboard chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.result       (result),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver: ready runs of mixed length, occasionally very long
	initial begin
		result_ready = 1'b0;
		rdy_on       = 1'b0;
		rdy_run      = 0;
		forever begin
			@(negedge clk);
			if (rdy_run == 0) begin
				rdy_on  = !rdy_on;
				rdy_run = rdy_on ? (($urandom_range(0, 3) == 0) ? $urandom_range(200, 3000)
					: $urandom_range(1, 30)) : $urandom_range(1, 6);
			end
			rdy_run--;
			result_ready = rdy_on;
		end
	end

	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	task automatic send(input hfd_item_t w);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 2500) : $urandom_range(0, 5);
			if (gap > 0) begin
				item_valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		item       = w;
		item_valid = 1'b1;
		do @(posedge clk); while (!item_ready);
		@(negedge clk);
		burst_left--;
		words_sent++;
	endtask

	task automatic load_entry(input int idx, input logic [31:0] code, input int len);
		hfd_item_t w;
		w.mode         = MODE_LOAD;
		w.entry_symbol = SYM_W'(idx);
		w.entry_code   = code;
		w.entry_length = LEN_W'(len);
		w.data_byte    = BYTE_W'($urandom_range(0, 255));
		w.last_byte    = 1'($urandom_range(0, 1));
		send(w);
	endtask

	task automatic put_byte(input int data, input bit last);
		hfd_item_t w;
		w.mode         = MODE_BYTE;
		w.entry_symbol = SYM_W'($urandom_range(0, 255));
		w.entry_code   = $urandom;
		w.entry_length = LEN_W'($urandom_range(0, 63));
		w.data_byte    = BYTE_W'(data);
		w.last_byte    = last;
		send(w);
	endtask

	// clears the previous table, then loads a random prefix code (sometimes missing one leaf)
	task automatic random_table();
		logic [31:0] leaf_code [$];
		int          leaf_len  [$];
		bit          taken     [TABLE_ENTRIES];
		int          leaves;
		int          pick;
		int          drop;
		int          idx;
		int          depth;
		logic [31:0] c;
		logic [31:0] mask;
		foreach (loaded_syms[k])
			load_entry(loaded_syms[k], $urandom, 0);
		loaded_syms.delete();
		leaf_code.push_back(32'd0);
		leaf_code.push_back(32'd1);
		leaf_len.push_back(1);
		leaf_len.push_back(1);
		leaves = $urandom_range(2, 10);
		while (leaf_len.size() < leaves) begin
			pick  = $urandom_range(0, leaf_len.size() - 1);
			c     = leaf_code[pick];
			depth = leaf_len[pick];
			leaf_code.delete(pick);
			leaf_len.delete(pick);
			leaf_code.push_back(c << 1);
			leaf_code.push_back((c << 1) | 32'd1);
			leaf_len.push_back(depth + 1);
			leaf_len.push_back(depth + 1);
		end
		drop = ($urandom_range(0, 2) == 0) ? $urandom_range(0, leaves - 1) : -1;
		foreach (leaf_len[k]) begin
			if (k != drop) begin
				do idx = $urandom_range(0, 255); while (taken[idx]);
				taken[idx] = 1'b1;
				mask = (32'd1 << leaf_len[k]) - 32'd1;
				load_entry(idx, ($urandom & ~mask) | leaf_code[k], leaf_len[k]);
				loaded_syms.push_back(idx);
			end
		end
		// same code at a second index: lower index must win
		if ($urandom_range(0, 2) == 0) begin
			pick = $urandom_range(0, leaves - 1);
			do idx = $urandom_range(0, 255); while (taken[idx]);
			mask = (32'd1 << leaf_len[pick]) - 32'd1;
			load_entry(idx, ($urandom & ~mask) | leaf_code[pick], leaf_len[pick]);
			loaded_syms.push_back(idx);
		end
	endtask

	task automatic random_stream();
		int pad;
		int nbytes;
		int idx;
		pad    = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 255) : $urandom_range(0, 8);
		nbytes = $urandom_range(0, 6);
		put_byte(pad, nbytes == 0);
		for (int k = 0; k < nbytes; k++) begin
			if ($urandom_range(0, 15) == 0) begin
				idx = $urandom_range(0, 255);
				load_entry(idx, $urandom, $urandom_range(0, 63));
				loaded_syms.push_back(idx);
			end
			put_byte($urandom_range(0, 255), k == nbytes - 1);
		end
	endtask

	initial begin
		arst_n     = 1'b0;
		item       = '0;
		item_valid = 1'b0;
		burst_left = 0;
		words_sent = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty table: 32 ones overflow on the last byte
		put_byte(0, 1'b0);
		repeat (3) put_byte(8'hFF, 1'b0);
		put_byte(8'hFF, 1'b1);

		load_entry(8'h80, 32'h0000_0000, 1);
		load_entry(8'h00, 32'hFFFF_FFFE, 1);
		load_entry(8'h55, 32'h5555_5556, 2);
		load_entry(8'hFF, 32'hFFFF_FFFF, 32);
		load_entry(8'h10, 32'h0000_0000, 40);
		load_entry(8'h20, 32'h0000_0001, 0);
		loaded_syms = '{8'h80, 8'h00, 8'h55, 8'hFF, 8'h10, 8'h20};

		// padding 3, two leftover bits dropped at end
		put_byte(3, 1'b0);
		put_byte(8'hA4, 1'b0);
		put_byte(8'h5F, 1'b1);
		// full-length code
		put_byte(0, 1'b0);
		repeat (3) put_byte(8'hFF, 1'b0);
		put_byte(8'hFF, 1'b1);
		// bad padding, then whole last byte dropped
		put_byte(9, 1'b0);
		put_byte(8'h00, 1'b1);
		// bad padding on an empty stream
		put_byte(8'hFF, 1'b1);
		// empty stream
		put_byte(5, 1'b1);
		// padding 8
		put_byte(8, 1'b0);
		put_byte(8'h00, 1'b1);
		// eight symbols from one byte
		put_byte(0, 1'b0);
		put_byte(8'h00, 1'b1);

		while (words_sent < ITEM_COUNT) begin
			random_table();
			repeat ($urandom_range(2, 4)) random_stream();
		end
		item_valid = 1'b0;

		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule

@@ files.f @@
design/hfd_pkg.sv
design/hfd_ram.sv
design/hfd_front.sv
design/hfd_queue.sv
design/hfd_back.sv
design/huffman_table_decoder.sv
design/hfd_checker.sv
verif/hfd_checker.sv
verif/tb_top.sv
